@@ rtl/core/pcfd_pkg.sv @@
// Package for the paired-contact feedback debounce core: widths, types, defaults.
package pcfd_pkg;

  // Field widths
  localparam int unsigned RawW   = 16;
  localparam int unsigned StampW = 32;
  localparam int unsigned DbW    = 16;
  localparam int unsigned MaskW  = 8;

  // Defaults
  localparam int unsigned GroupsDefault   = 8;
  localparam logic [DbW-1:0] DebounceReset = DbW'(20);

  // Request codes
  typedef enum logic {
    REQ_INIT   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

  // One contact pair: positive and negative contact
  typedef struct packed {
    logic neg;
    logic pos;
  } pair_t;

endpackage

@@ rtl/core/pcfd_in_if.sv @@
// Input channel: one feedback sample with its request type and timestamp.
interface pcfd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [pcfd_pkg::RawW-1:0]      feedback_bits;
  logic [pcfd_pkg::StampW-1:0]    now_ms;

  modport source (output valid, req_type, feedback_bits, now_ms, input ready);
  modport sink   (input valid, req_type, feedback_bits, now_ms, output ready);
endinterface

@@ rtl/core/pcfd_out_if.sv @@
// Output channel: raw word and classification masks of the stable pairs.
interface pcfd_out_if;
  logic                           valid;
  logic                           ready;
  logic [pcfd_pkg::RawW-1:0]      raw_word;
  logic [pcfd_pkg::MaskW-1:0]     on_groups;
  logic [pcfd_pkg::MaskW-1:0]     off_groups;
  logic [pcfd_pkg::MaskW-1:0]     mismatch_groups;
  logic [pcfd_pkg::MaskW-1:0]     stable_positive;
  logic [pcfd_pkg::MaskW-1:0]     stable_negative;

  modport source (output valid, raw_word, on_groups, off_groups, mismatch_groups,
                  stable_positive, stable_negative, input ready);
  modport sink   (input valid, raw_word, on_groups, off_groups, mismatch_groups,
                  stable_positive, stable_negative, output ready);
endinterface

@@ rtl/core/pcfd_lane.sv @@
// Debounce lane for one contact group: stable pair, candidate pair and stamp.
module pcfd_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        req_i,
  input  pcfd_pkg::pair_t             raw_pair_i,
  input  logic [pcfd_pkg::StampW-1:0] now_i,
  input  logic [pcfd_pkg::DbW-1:0]    debounce_i,
  output pcfd_pkg::pair_t             stable_d_o
);

  pcfd_pkg::pair_t                 stable_q, stable_d;
  pcfd_pkg::pair_t                 cand_q, cand_d;
  logic [pcfd_pkg::StampW-1:0]     stamp_q, stamp_d;
  logic [pcfd_pkg::StampW-1:0]     elapsed;

  // Init load, else candidate tracking and promotion after the debounce time
  always_comb begin
    cand_d   = cand_q;
    stamp_d  = stamp_q;
    stable_d = stable_q;
    elapsed  = '0;
    if (req_i == pcfd_pkg::REQ_INIT) begin
      stable_d = raw_pair_i;
      cand_d   = raw_pair_i;
      stamp_d  = now_i;
    end else begin
      if (raw_pair_i != cand_q) begin
        cand_d  = raw_pair_i;
        stamp_d = now_i;
      end
      elapsed = now_i - stamp_d;
      if ((stable_q != cand_d) &&
          (elapsed >= {{(pcfd_pkg::StampW-pcfd_pkg::DbW){1'b0}}, debounce_i})) begin
        stable_d = cand_d;
      end
    end
  end

  // Lane state, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      cand_q   <= '0;
      stamp_q  <= '0;
    end else if (en_i) begin
      stable_q <= stable_d;
      cand_q   <= cand_d;
      stamp_q  <= stamp_d;
    end
  end

  assign stable_d_o = stable_d;

endmodule

@@ rtl/core/pcfd_merge.sv @@
// Merge stage: classifies the lanes' stable pairs and holds the output register.
module pcfd_merge #(
  parameter int unsigned Lanes = pcfd_pkg::MaskW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [pcfd_pkg::RawW-1:0] raw_i,
  input  pcfd_pkg::pair_t [Lanes-1:0] pairs_i,
  output logic                      load_ready_o,
  pcfd_out_if.source                out_o
);

  logic                         valid_q;
  logic [pcfd_pkg::RawW-1:0]    raw_q;
  logic [pcfd_pkg::MaskW-1:0]   on_d, off_d, mis_d, pos_d, neg_d;
  logic [pcfd_pkg::MaskW-1:0]   on_q, off_q, mis_q, pos_q, neg_q;

  // Per-group classification; masks above the lane count stay zero
  always_comb begin
    on_d  = '0;
    off_d = '0;
    mis_d = '0;
    pos_d = '0;
    neg_d = '0;
    for (int unsigned g = 0; g < Lanes; g++) begin
      on_d[g]  = pairs_i[g].pos & pairs_i[g].neg;
      off_d[g] = ~pairs_i[g].pos & ~pairs_i[g].neg;
      mis_d[g] = pairs_i[g].pos ^ pairs_i[g].neg;
      pos_d[g] = pairs_i[g].pos;
      neg_d[g] = pairs_i[g].neg;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      raw_q <= raw_i;
      on_q  <= on_d;
      off_q <= off_d;
      mis_q <= mis_d;
      pos_q <= pos_d;
      neg_q <= neg_d;
    end
  end

  assign load_ready_o          = ~valid_q | out_o.ready;
  assign out_o.valid           = valid_q;
  assign out_o.raw_word        = raw_q;
  assign out_o.on_groups       = on_q;
  assign out_o.off_groups      = off_q;
  assign out_o.mismatch_groups = mis_q;
  assign out_o.stable_positive = pos_q;
  assign out_o.stable_negative = neg_q;

endmodule

@@ rtl/core/paired_contact_feedback_debounce_core.sv @@
// Top level of the paired-contact feedback debounce core.
// The result of an input transfer is valid in the output register in the next cycle.
// Throughput: one sample per cycle while the output is not stalled; all group lanes update in the same cycle.
// A new sample is taken while the output register is empty or being drained.
// Reset: all pairs, stamps and the output valid clear; debounce time resets to 20 ms.
module paired_contact_feedback_debounce_core #(
  parameter int unsigned GROUPS = pcfd_pkg::GroupsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pcfd_pkg::DbW-1:0] cfg_wdata_i,
  pcfd_in_if.sink                  in_i,
  pcfd_out_if.source               out_o
);

  localparam int unsigned OutLanes = (GROUPS < pcfd_pkg::MaskW) ? GROUPS : pcfd_pkg::MaskW;

  logic [pcfd_pkg::DbW-1:0]        debounce_q;
  logic                            load_ready;
  logic                            accept;
  pcfd_pkg::pair_t [GROUPS-1:0]    raw_pairs;
  pcfd_pkg::pair_t [GROUPS-1:0]    stable_pairs;

  // Debounce time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= pcfd_pkg::DebounceReset;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = load_ready;
  assign accept     = in_i.valid & load_ready;

  // One lane per group; groups past the raw word see open contacts
  for (genvar g = 0; g < GROUPS; g++) begin : g_lane
    if (2 * g + 1 < pcfd_pkg::RawW) begin : g_in_word
      assign raw_pairs[g].pos = in_i.feedback_bits[2*g];
      assign raw_pairs[g].neg = in_i.feedback_bits[2*g+1];
    end else begin : g_beyond
      assign raw_pairs[g] = '0;
    end

    pcfd_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .req_i      (in_i.req_type),
      .raw_pair_i (raw_pairs[g]),
      .now_i      (in_i.now_ms),
      .debounce_i (debounce_q),
      .stable_d_o (stable_pairs[g])
    );
  end

  pcfd_merge #(
    .Lanes (OutLanes)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .raw_i        (in_i.feedback_bits),
    .pairs_i      (stable_pairs[OutLanes-1:0]),
    .load_ready_o (load_ready),
    .out_o        (out_o)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the paired-contact feedback debounce core.
module testbench;

  localparam int unsigned NGroups = pcfd_pkg::GroupsDefault;

  // One expected or observed result
  typedef struct packed {
    logic [pcfd_pkg::RawW-1:0]  raw_word;
    logic [pcfd_pkg::MaskW-1:0] on_groups;
    logic [pcfd_pkg::MaskW-1:0] off_groups;
    logic [pcfd_pkg::MaskW-1:0] mismatch_groups;
    logic [pcfd_pkg::MaskW-1:0] stable_positive;
    logic [pcfd_pkg::MaskW-1:0] stable_negative;
  } contact_status_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [pcfd_pkg::DbW-1:0] cfg_wdata_i;

  pcfd_in_if  sample_ch ();
  pcfd_out_if status_ch ();

  paired_contact_feedback_debounce_core #(
    .GROUPS(NGroups)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (sample_ch),
    .out_o      (status_ch)
  );

  // Shadow copy of the debounce state
  pcfd_pkg::pair_t             stable_pair [NGroups];
  pcfd_pkg::pair_t             cand_pair   [NGroups];
  logic [pcfd_pkg::StampW-1:0] cand_stamp  [NGroups];
  logic [pcfd_pkg::DbW-1:0]    debounce_ms;

  contact_status_t expected_status_q[$];
  int              error_count;

  // Traffic shaping knobs
  int              feed_idle_pct;
  int              drain_idle_pct;
  int              drain_hold_req;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Debounce prediction for one accepted sample; updates the shadow state
  function automatic contact_status_t debounce_predict(pcfd_pkg::req_e req,
                                                       logic [pcfd_pkg::RawW-1:0] bits,
                                                       logic [pcfd_pkg::StampW-1:0] now_ms);
    contact_status_t st;
    pcfd_pkg::pair_t raw_pair;
    st          = '0;
    st.raw_word = bits;
    for (int g = 0; g < NGroups; g++) begin
      raw_pair = pcfd_pkg::pair_t'(bits[2*g +: 2]);
      if (req == pcfd_pkg::REQ_INIT) begin
        stable_pair[g] = raw_pair;
        cand_pair[g]   = raw_pair;
        cand_stamp[g]  = now_ms;
      end else begin
        if (raw_pair != cand_pair[g]) begin
          cand_pair[g]  = raw_pair;
          cand_stamp[g] = now_ms;
        end
        // elapsed time wraps modulo 2^32
        if (stable_pair[g] != cand_pair[g] &&
            (now_ms - cand_stamp[g]) >= pcfd_pkg::StampW'(debounce_ms)) begin
          stable_pair[g] = cand_pair[g];
        end
      end
      st.on_groups[g]       = stable_pair[g].pos & stable_pair[g].neg;
      st.off_groups[g]      = ~stable_pair[g].pos & ~stable_pair[g].neg;
      st.mismatch_groups[g] = stable_pair[g].pos ^ stable_pair[g].neg;
      st.stable_positive[g] = stable_pair[g].pos;
      st.stable_negative[g] = stable_pair[g].neg;
    end
    return st;
  endfunction

  // Offer one sample, wait for its transfer, record the expected status
  task automatic send_sample(pcfd_pkg::req_e req, logic [pcfd_pkg::RawW-1:0] bits,
                             logic [pcfd_pkg::StampW-1:0] now_ms);
    while ($urandom_range(99) < feed_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.req_type      <= req;
    sample_ch.feedback_bits <= bits;
    sample_ch.now_ms        <= now_ms;
    do @(posedge clk_i); while (!sample_ch.ready);
    expected_status_q.push_back(debounce_predict(req, bits, now_ms));
  endtask

  // Stop offering and let every pending status drain
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_debounce(logic [pcfd_pkg::DbW-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    debounce_ms = value;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    status_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        status_ch.ready <= 1'b0;
      end else if (drain_hold_req > 0) begin
        status_ch.ready <= 1'b0;
        drain_hold_req--;
      end else begin
        status_ch.ready <= ($urandom_range(99) >= drain_idle_pct);
      end
    end
  end

  task automatic flag_field(string field, logic [pcfd_pkg::RawW-1:0] want,
                            logic [pcfd_pkg::RawW-1:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= 10) begin
        $display("status mismatch on %s: expected %h, got %h", field, want, got);
      end
    end
  endtask

  // Compare every status transfer with the oldest expectation
  always @(posedge clk_i) begin : check_status
    contact_status_t want;
    if (rst_ni && status_ch.valid && status_ch.ready) begin
      if (expected_status_q.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("status transfer with no sample pending: raw %h", status_ch.raw_word);
        end
      end else begin
        want = expected_status_q.pop_front();
        flag_field("raw_word", want.raw_word, status_ch.raw_word);
        flag_field("on_groups", pcfd_pkg::RawW'(want.on_groups),
                   pcfd_pkg::RawW'(status_ch.on_groups));
        flag_field("off_groups", pcfd_pkg::RawW'(want.off_groups),
                   pcfd_pkg::RawW'(status_ch.off_groups));
        flag_field("mismatch_groups", pcfd_pkg::RawW'(want.mismatch_groups),
                   pcfd_pkg::RawW'(status_ch.mismatch_groups));
        flag_field("stable_positive", pcfd_pkg::RawW'(want.stable_positive),
                   pcfd_pkg::RawW'(status_ch.stable_positive));
        flag_field("stable_negative", pcfd_pkg::RawW'(want.stable_negative),
                   pcfd_pkg::RawW'(status_ch.stable_negative));
      end
    end
  end

  // After reset all pairs are off; a change must persist for the default time
  task automatic test_reset_state();
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'h0000, 32'd0);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'h0003, 32'd1);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'h0003, 32'd20);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'h0003, 32'd21);
  endtask

  // Init loads stable pairs directly: on, off, one-sided contacts
  task automatic test_init();
    send_sample(pcfd_pkg::REQ_INIT, 16'hFFFF, 32'd100);
    send_sample(pcfd_pkg::REQ_INIT, 16'h0000, 32'd101);
    send_sample(pcfd_pkg::REQ_INIT, 16'hAAAA, 32'd102);
    send_sample(pcfd_pkg::REQ_INIT, 16'h5555, 32'd103);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'h5555, 32'd104);
  endtask

  // Zero debounce: a new candidate is stable at once
  task automatic test_zero_debounce();
    write_debounce(16'd0);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'h00FF, 32'd200);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'h9C3A, 32'd200);
    write_debounce(pcfd_pkg::DebounceReset);
  endtask

  // Elapsed time across the 32-bit wrap
  task automatic test_timestamp_wrap();
    send_sample(pcfd_pkg::REQ_INIT, 16'h0000, 32'hFFFF_FFF0);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'hFFFF, 32'hFFFF_FFF8);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'hFFFF, 32'h0000_000B);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'hFFFF, 32'h0000_000C);
  endtask

  // Longest debounce time, with a bounce that restarts the candidate stamp
  task automatic test_max_debounce();
    write_debounce(16'hFFFF);
    send_sample(pcfd_pkg::REQ_INIT, 16'h0000, 32'd1000);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'hFFFF, 32'd2000);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'hFFFE, 32'd3000);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'hFFFF, 32'd3001);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'hFFFF, 32'd3001 + 32'd65534);
    send_sample(pcfd_pkg::REQ_SAMPLE, 16'hFFFF, 32'd3001 + 32'd65535);
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    logic [pcfd_pkg::StampW-1:0] now_ms;
    now_ms         = $urandom;
    feed_idle_pct  = 0;
    drain_hold_req = 60;
    repeat (16) begin
      now_ms = now_ms + $urandom_range(0, 12);
      send_sample(pcfd_pkg::REQ_SAMPLE, 16'($urandom), now_ms);
    end
    feed_idle_pct = 38;
  endtask

  // Settling contacts with bounces, occasional re-init, and some noise
  task automatic run_random_phase(logic [pcfd_pkg::DbW-1:0] db, int count);
    logic [pcfd_pkg::RawW-1:0]   settled;
    logic [pcfd_pkg::RawW-1:0]   bits;
    logic [pcfd_pkg::StampW-1:0] now_ms;
    int                          delta;
    pcfd_pkg::req_e              req;
    write_debounce(db);
    settled = pcfd_pkg::RawW'($urandom);
    now_ms  = $urandom;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: delta = $urandom_range(0, int'(db) / 4 + 2);
        6, 7:             delta = int'(db) - 1 + $urandom_range(0, 2);
        8:                delta = $urandom_range(0, 3 * int'(db) + 3);
        default:          delta = $urandom;
      endcase
      now_ms = now_ms + pcfd_pkg::StampW'(delta);
      if ($urandom_range(99) < 10) settled = pcfd_pkg::RawW'($urandom);
      case ($urandom_range(9))
        0, 1:    bits = settled ^ (pcfd_pkg::RawW'(1) << $urandom_range(pcfd_pkg::RawW - 1));
        2:       bits = pcfd_pkg::RawW'($urandom);
        default: bits = settled;
      endcase
      req = ($urandom_range(99) < 5) ? pcfd_pkg::REQ_INIT : pcfd_pkg::REQ_SAMPLE;
      send_sample(req, bits, now_ms);
    end
  endtask

  task automatic test_random();
    run_random_phase(pcfd_pkg::DebounceReset, 250);
    run_random_phase(16'd0, 200);
    run_random_phase(16'hFFFF, 200);
    // stretch without any idling on either side
    feed_idle_pct  = 0;
    drain_idle_pct = 0;
    run_random_phase(16'd1, 250);
    feed_idle_pct  = 38;
    drain_idle_pct = 38;
    run_random_phase(pcfd_pkg::DbW'($urandom_range(2, 5000)), 250);
  endtask

  // Main sequence
  initial begin
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_wdata_i             = '0;
    sample_ch.valid         = 1'b0;
    sample_ch.req_type      = pcfd_pkg::REQ_INIT;
    sample_ch.feedback_bits = '0;
    sample_ch.now_ms        = '0;
    error_count             = 0;
    feed_idle_pct           = 38;
    drain_idle_pct          = 38;
    drain_hold_req          = 0;
    debounce_ms             = pcfd_pkg::DebounceReset;
    for (int g = 0; g < NGroups; g++) begin
      stable_pair[g] = '0;
      cand_pair[g]   = '0;
      cand_stamp[g]  = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_init();
    test_zero_debounce();
    test_timestamp_wrap();
    test_max_debounce();
    test_backpressure();
    test_random();

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (error_count == 0 && expected_status_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pcfd_pkg.sv
rtl/core/pcfd_in_if.sv
rtl/core/pcfd_out_if.sv
rtl/core/pcfd_lane.sv
rtl/core/pcfd_merge.sv
rtl/core/paired_contact_feedback_debounce_core.sv
tb/testbench.sv
